// ----- rtl/appsp_pkg.sv -----
// Shared types and constants of the ASCII PPM P3 stream parser.
// Holds the request, response and internal command formats and the byte codes.
// No dependencies.
`default_nettype none

package appsp_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_DIMENSION_DEF = 4096;
   localparam int FRACTION_BITS_DEF = 16;

   // Depth of the command queue between parser and back end (power of two)
   localparam int CMD_DEPTH = 4;

   // Result kinds
   localparam logic [2:0] KIND_WIDTH  = 3'd0;
   localparam logic [2:0] KIND_HEIGHT = 3'd1;
   localparam logic [2:0] KIND_MAXVAL = 3'd2;
   localparam logic [2:0] KIND_RED    = 3'd3;
   localparam logic [2:0] KIND_GREEN  = 3'd4;
   localparam logic [2:0] KIND_BLUE   = 3'd5;
   localparam logic [2:0] KIND_ERROR  = 3'd6;

   // Error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
   localparam logic [2:0] ERR_MALFORMED   = 3'd2;
   localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
   localparam logic [2:0] ERR_BAD_SAMPLE  = 3'd4;

   // Character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_P     = 8'h50;

   // Largest header value reported
   localparam logic [16:0] REPORT_MAX = 17'h1FFFF;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [16:0] value;
      logic [2:0]  error_code;
      logic        last_of_image;
   } rsp_type;

   // One unit of work for the back end; a divide command carries the
   // clamped sample in value[15:0] and the max value in divisor
   typedef struct packed {
      logic        is_div;
      logic [2:0]  kind;
      logic [16:0] value;
      logic [2:0]  code;
      logic        last;
      logic [15:0] divisor;
   } cmd_type;

   // Up to two commands produced by one input byte
   typedef struct packed {
      logic [1:0] count;
      cmd_type    first;
      cmd_type    second;
   } cmd_pair_type;

endpackage

`default_nettype wire

// ----- rtl/appsp_front.sv -----
// Front end: tokenizes the byte stream and runs the header and sample phases.
// Produces up to two commands per byte for the back end. Uses appsp_pkg.
`default_nettype none

module appsp_front #(
   parameter int MAX_DIMENSION = appsp_pkg::MAX_DIMENSION_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  appsp_pkg::req_type      req_item,
   input  wire                     accept,
   output appsp_pkg::cmd_pair_type cmds
);
   import appsp_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int PIX_W = 2 * DIM_W;

   localparam logic [2:0] PH_MAGIC   = 3'd0;
   localparam logic [2:0] PH_WIDTH   = 3'd1;
   localparam logic [2:0] PH_HEIGHT  = 3'd2;
   localparam logic [2:0] PH_MAXV    = 3'd3;
   localparam logic [2:0] PH_SAMPLES = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;
   localparam logic [2:0] PH_ERROR   = 3'd6;

   logic [2:0]       phase_ff, phase_in;
   logic [31:0]      tok_ff, tok_in;
   logic             tin_ff, tin_in;
   logic             neg_ff, neg_in;
   logic             dig_ff, dig_in;
   logic             bad_ff, bad_in;
   logic             cmt_ff, cmt_in;
   logic [1:0]       mpos_ff, mpos_in;
   logic [DIM_W-1:0] wid_ff, wid_in;
   logic [DIM_W-1:0] hgt_ff, hgt_in;
   logic [15:0]      max_ff, max_in;
   logic [PIX_W-1:0] left_ff, left_in;
   logic [1:0]       chan_ff, chan_in;

   logic [7:0]       ch;
   logic             eos;
   logic             is_space;
   logic             is_digit;
   logic [35:0]      acc;
   logic             acc_over;
   logic             tok_ok;
   logic             tok_pos;
   logic [16:0]      hdr_rep;
   logic             dim_ok;
   logic             max_ok;
   logic [15:0]      samp;
   logic [PIX_W-1:0] left_dec;

   function automatic cmd_type direct_cmd(logic [2:0] kind, logic [16:0] value,
                                          logic [2:0] code);
      cmd_type c;
      c         = '0;
      c.kind    = kind;
      c.value   = value;
      c.code    = code;
      return c;
   endfunction

   // Classify the byte
   assign ch       = req_item.stream_byte;
   assign eos      = req_item.end_of_stream;
   assign is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                     (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

   // Accumulate one decimal digit, saturating just past 2^31
   assign acc      = ({4'd0, tok_ff} << 3) + ({4'd0, tok_ff} << 1) + 36'(ch[3:0]);
   assign acc_over = acc > 36'h0_8000_0000;

   // Decode the finished token
   assign tok_ok  = !bad_ff && dig_ff && (neg_ff || !tok_ff[31]);
   assign tok_pos = !neg_ff && (tok_ff != 32'd0);
   assign hdr_rep = neg_ff ? 17'd0 :
                    ((tok_ff > 32'(REPORT_MAX)) ? REPORT_MAX : tok_ff[16:0]);
   assign dim_ok  = tok_pos && (tok_ff <= 32'(MAX_DIMENSION));
   assign max_ok  = tok_pos && (tok_ff[31:16] == 16'd0);
   assign samp    = neg_ff ? 16'd0 :
                    ((tok_ff > 32'(max_ff)) ? max_ff : tok_ff[15:0]);
   assign left_dec = (left_ff != '0) ? left_ff - PIX_W'(1) : left_ff;

   // Next state and commands
   always_comb begin
      logic       fin;
      logic [1:0] n;
      cmd_type    e;

      phase_in = phase_ff;
      tok_in   = tok_ff;
      tin_in   = tin_ff;
      neg_in   = neg_ff;
      dig_in   = dig_ff;
      bad_in   = bad_ff;
      cmt_in   = cmt_ff;
      mpos_in  = mpos_ff;
      wid_in   = wid_ff;
      hgt_in   = hgt_ff;
      max_in   = max_ff;
      left_in  = left_ff;
      chan_in  = chan_ff;
      cmds     = '0;
      fin      = 1'b0;
      n        = 2'd0;
      e        = '0;

      // Tokenize the byte
      if (accept) begin
         if (eos) begin
            fin = (phase_ff < PH_DONE) && tin_ff && !cmt_ff;
         end else if (phase_ff < PH_DONE) begin
            if (cmt_ff) begin
               if (ch == CH_LF) begin
                  cmt_in = 1'b0;
                  tin_in = 1'b0;
                  neg_in = 1'b0;
                  dig_in = 1'b0;
                  bad_in = 1'b0;
               end
            end else if (is_space) begin
               fin = tin_ff;
            end else if (!tin_ff && (ch == CH_HASH)) begin
               cmt_in = 1'b1;
            end else begin
               tin_in = 1'b1;
               if (phase_ff == PH_MAGIC) begin
                  if ((mpos_ff == 2'd0) && (ch == CH_P)) begin
                     mpos_in = 2'd1;
                  end else if ((mpos_ff == 2'd1) && (ch == CH_THREE)) begin
                     mpos_in = 2'd2;
                  end else begin
                     bad_in = 1'b1;
                  end
               end else if (!tin_ff && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
                  if (ch == CH_MINUS) begin
                     neg_in = 1'b1;
                  end
               end else if (is_digit) begin
                  dig_in = 1'b1;
                  if (acc_over) begin
                     bad_in = 1'b1;
                     tok_in = 32'h8000_0001;
                  end else begin
                     tok_in = acc[31:0];
                  end
               end else begin
                  bad_in = 1'b1;
               end
            end
         end
      end

      // Finish the pending token
      if (fin) begin
         tok_in  = '0;
         tin_in  = 1'b0;
         neg_in  = 1'b0;
         dig_in  = 1'b0;
         bad_in  = 1'b0;
         cmt_in  = 1'b0;
         mpos_in = 2'd0;
         case (phase_ff)
            PH_MAGIC: begin
               if (!bad_ff && (mpos_ff == 2'd2)) begin
                  phase_in = PH_WIDTH;
               end else begin
                  cmds.first = direct_cmd(KIND_ERROR, 17'd0, ERR_BAD_MAGIC);
                  n          = 2'd1;
                  phase_in   = PH_ERROR;
               end
            end
            PH_WIDTH: begin
               if (!tok_ok) begin
                  cmds.first = direct_cmd(KIND_ERROR, 17'd0, ERR_MALFORMED);
                  phase_in   = PH_ERROR;
               end else begin
                  cmds.first = direct_cmd(KIND_WIDTH, hdr_rep, ERR_NONE);
                  wid_in     = dim_ok ? tok_ff[DIM_W-1:0] : '0;
                  phase_in   = PH_HEIGHT;
               end
               n = 2'd1;
            end
            PH_HEIGHT: begin
               if (!tok_ok) begin
                  cmds.first = direct_cmd(KIND_ERROR, 17'd0, ERR_MALFORMED);
                  phase_in   = PH_ERROR;
               end else begin
                  cmds.first = direct_cmd(KIND_HEIGHT, hdr_rep, ERR_NONE);
                  hgt_in     = dim_ok ? tok_ff[DIM_W-1:0] : '0;
                  phase_in   = PH_MAXV;
               end
               n = 2'd1;
            end
            PH_MAXV: begin
               if (!tok_ok) begin
                  cmds.first = direct_cmd(KIND_ERROR, 17'd0, ERR_MALFORMED);
                  phase_in   = PH_ERROR;
                  n          = 2'd1;
               end else begin
                  cmds.first = direct_cmd(KIND_MAXVAL, hdr_rep, ERR_NONE);
                  max_in     = max_ok ? tok_ff[15:0] : 16'd0;
                  n          = 2'd1;
                  if ((wid_ff == '0) || (hgt_ff == '0) || !max_ok) begin
                     cmds.second = direct_cmd(KIND_ERROR, 17'd0, ERR_UNSUPPORTED);
                     n           = 2'd2;
                     phase_in    = PH_ERROR;
                  end else begin
                     left_in  = PIX_W'(wid_ff) * PIX_W'(hgt_ff);
                     chan_in  = 2'd0;
                     phase_in = PH_SAMPLES;
                  end
               end
            end
            PH_SAMPLES: begin
               if (!tok_ok || (max_ff == 16'd0)) begin
                  cmds.first = direct_cmd(KIND_ERROR, 17'd0, ERR_BAD_SAMPLE);
                  phase_in   = PH_ERROR;
               end else begin
                  e         = '0;
                  e.is_div  = 1'b1;
                  e.kind    = KIND_RED + {1'b0, chan_ff};
                  e.value   = {1'b0, samp};
                  e.code    = ERR_NONE;
                  e.last    = (left_ff == PIX_W'(1)) && (chan_ff == 2'd2);
                  e.divisor = max_ff;
                  cmds.first = e;
                  if (chan_ff >= 2'd2) begin
                     chan_in = 2'd0;
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        phase_in = PH_DONE;
                     end
                  end else begin
                     chan_in = chan_ff + 2'd1;
                  end
               end
               n = 2'd1;
            end
            default: begin
            end
         endcase
      end

      // On end of stream, raise an error unless the image is done or already in error, and return to reset state
      if (accept && eos) begin
         e = '0;
         case (phase_in)
            PH_MAGIC: e = direct_cmd(KIND_ERROR, 17'd0, ERR_BAD_MAGIC);
            PH_WIDTH, PH_HEIGHT, PH_MAXV: e = direct_cmd(KIND_ERROR, 17'd0, ERR_MALFORMED);
            PH_SAMPLES: e = direct_cmd(KIND_ERROR, 17'd0, ERR_BAD_SAMPLE);
            default: e = '0;
         endcase
         if ((phase_in == PH_MAGIC) || (phase_in == PH_WIDTH) ||
             (phase_in == PH_HEIGHT) || (phase_in == PH_MAXV) ||
             (phase_in == PH_SAMPLES)) begin
            if (n == 2'd0) begin
               cmds.first = e;
            end else begin
               cmds.second = e;
            end
            n = n + 2'd1;
         end
         phase_in = PH_MAGIC;
         tok_in   = '0;
         tin_in   = 1'b0;
         neg_in   = 1'b0;
         dig_in   = 1'b0;
         bad_in   = 1'b0;
         cmt_in   = 1'b0;
         mpos_in  = 2'd0;
         wid_in   = '0;
         hgt_in   = '0;
         max_in   = 16'd0;
         left_in  = '0;
         chan_in  = 2'd0;
      end

      cmds.count = n;
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         tok_ff   <= '0;
         tin_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         dig_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         cmt_ff   <= 1'b0;
         mpos_ff  <= 2'd0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         max_ff   <= 16'd0;
         left_ff  <= '0;
         chan_ff  <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         tok_ff   <= tok_in;
         tin_ff   <= tin_in;
         neg_ff   <= neg_in;
         dig_ff   <= dig_in;
         bad_ff   <= bad_in;
         cmt_ff   <= cmt_in;
         mpos_ff  <= mpos_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         max_ff   <= max_in;
         left_ff  <= left_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/appsp_cmd_fifo.sv -----
// Command queue between parser front end and back end.
// Takes up to two commands per cycle, gives one per cycle. Uses appsp_pkg.
`default_nettype none

module appsp_cmd_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  appsp_pkg::cmd_pair_type cmds,
   output logic                    room,
   output appsp_pkg::cmd_type      head,
   output logic                    avail,
   input  wire                     take
);
   import appsp_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type          slot_ff [CMD_DEPTH];
   cmd_type          slot_in [CMD_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] wnext;

   assign room  = cnt_ff <= CNT_W'(CMD_DEPTH - 2);
   assign avail = cnt_ff != '0;
   assign head  = slot_ff[rptr_ff];
   assign wnext = wptr_ff + PTR_W'(1);

   // Write up to two entries, advance the pointers
   always_comb begin
      slot_in = slot_ff;
      if (cmds.count != 2'd0) begin
         slot_in[wptr_ff] = cmds.first;
      end
      if (cmds.count == 2'd2) begin
         slot_in[wnext] = cmds.second;
      end
      wptr_in = wptr_ff + PTR_W'(cmds.count);
      rptr_in = (take && avail) ? rptr_ff + PTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff + CNT_W'(cmds.count) - CNT_W'(take && avail);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/appsp_back.sv -----
// Back end: carries out queued commands and holds the result register.
// Normalizes samples with a one-bit-per-cycle restoring divider. Uses appsp_pkg.
`default_nettype none

module appsp_back #(
   parameter int FRACTION_BITS = appsp_pkg::FRACTION_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  appsp_pkg::cmd_type  head,
   input  wire                 avail,
   output logic                take,
   output appsp_pkg::rsp_type  rsp_item,
   output logic                empty,
   input  wire                 pop
);
   import appsp_pkg::*;

   localparam int QW   = FRACTION_BITS + 1;
   localparam int CW   = $clog2(QW + 1);

   localparam logic BK_IDLE = 1'b0;
   localparam logic BK_DIV  = 1'b1;

   logic          bk_ff, bk_in;
   logic [16:0]   rem_ff, rem_in;
   logic [15:0]   div_ff, div_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [CW-1:0] step_ff, step_in;
   logic [2:0]    kind_ff, kind_in;
   logic          last_ff, last_in;
   logic          ov_ff, ov_in;
   rsp_type       out_ff, out_in;

   logic          out_free;
   logic          ge;
   logic [16:0]   rdiff;
   logic [QW+16:0] quo_ext;

   assign out_free = !ov_ff || pop;
   assign empty    = !ov_ff;
   assign rsp_item = out_ff;

   // One restoring division step
   assign ge      = rem_ff >= {1'b0, div_ff};
   assign rdiff   = ge ? rem_ff - {1'b0, div_ff} : rem_ff;
   assign quo_ext = {17'd0, quo_ff};

   always_comb begin
      bk_in   = bk_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      kind_in = kind_ff;
      last_in = last_ff;
      out_in  = out_ff;
      ov_in   = ov_ff && !pop;
      take    = 1'b0;
      case (bk_ff)
         BK_IDLE: begin
            // Start a division, or pass a direct result to the output
            if (avail && head.is_div) begin
               take    = 1'b1;
               rem_in  = head.value;
               div_in  = head.divisor;
               quo_in  = '0;
               step_in = CW'(QW);
               kind_in = head.kind;
               last_in = head.last;
               bk_in   = BK_DIV;
            end else if (avail && out_free) begin
               take                 = 1'b1;
               out_in.kind          = head.kind;
               out_in.value         = head.value;
               out_in.error_code    = head.code;
               out_in.last_of_image = head.last;
               ov_in                = 1'b1;
            end
         end
         BK_DIV: begin
            // Iterate, then deliver the quotient when the output frees up
            if (step_ff != '0) begin
               quo_in  = {quo_ff[QW-2:0], ge};
               rem_in  = {rdiff[15:0], 1'b0};
               step_in = step_ff - CW'(1);
            end else if (out_free) begin
               out_in.kind          = kind_ff;
               out_in.value         = quo_ext[16:0];
               out_in.error_code    = ERR_NONE;
               out_in.last_of_image = last_ff;
               ov_in                = 1'b1;
               bk_in                = BK_IDLE;
            end
         end
         default: bk_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
      out_ff  <= out_in;
      if (reset) begin
         bk_ff   <= BK_IDLE;
         step_ff <= '0;
         ov_ff   <= 1'b0;
      end else begin
         bk_ff   <= bk_in;
         step_ff <= step_in;
         ov_ff   <= ov_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ascii_ppm_p3_stream_parser_top.sv -----
// ASCII PPM P3 stream parser. The front end takes one byte per cycle while the
// command queue has room for two entries; a header or error result passes
// through the command queue and the output register to the result ports, a sample
// also through the bit-serial divider in the back end. The back end takes no new
// command while the divider works on a sample; the full queue then holds off bytes.
// Reset (synchronous, active high) clears parser state, queue and output.
`default_nettype none

module ascii_ppm_p3_stream_parser_top #(
   parameter int MAX_DIMENSION = appsp_pkg::MAX_DIMENSION_DEF,
   parameter int FRACTION_BITS = appsp_pkg::FRACTION_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   output logic               full,
   input  appsp_pkg::req_type req_item,
   output logic               empty,
   input  wire                pop,
   output appsp_pkg::rsp_type rsp_item
);
   import appsp_pkg::*;

   cmd_pair_type cmds;
   cmd_type      head;
   logic         room;
   logic         avail;
   logic         take;
   logic         accept;

   assign full   = !room;
   assign accept = push && room;

   // Parse bytes into commands
   appsp_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_item(req_item),
      .accept  (accept),
      .cmds    (cmds)
   );

   // Queue commands
   appsp_cmd_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .cmds (cmds),
      .room (room),
      .head (head),
      .avail(avail),
      .take (take)
   );

   // Execute commands and hold the result
   appsp_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .avail   (avail),
      .take    (take),
      .rsp_item(rsp_item),
      .empty   (empty),
      .pop     (pop)
   );

endmodule

`default_nettype wire
